### src/mffrq_pkg.sv
// Package: types, constants and frame check for the mesh frame filter relay queue
`default_nettype none
package mffrq_pkg;
    localparam int QueueDepth = 10;
    localparam int MaxPayload = 64;
    localparam int QW = $clog2(QueueDepth);
    localparam int CW = $clog2(QueueDepth + 1);
    localparam int OW = $clog2(MaxPayload);
    localparam int MemDepth = QueueDepth * (2 ** OW);
    localparam int MW = QW + OW;
    localparam int HdrBytes = 6;

    typedef enum logic [1:0] {
        MODE_RX   = 2'd0,
        MODE_SEND = 2'd1,
        MODE_DONE = 2'd2,
        MODE_NONE = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_ACCEPTED = 3'd0,
        ST_SHORT    = 3'd1,
        ST_OTHER    = 3'd2,
        ST_NETWORK  = 3'd3,
        ST_BADSIZE  = 3'd4,
        ST_FULL     = 3'd5,
        ST_EMPTY    = 3'd6,
        ST_POPPED   = 3'd7
    } status_t;

    typedef enum logic [1:0] {
        REG_CLUSTER = 2'd0,
        REG_NETWORK = 2'd1,
        REG_GATEWAY = 2'd2,
        REG_NODE    = 2'd3
    } reg_index_t;

    typedef enum logic [1:0] {
        FSM_IDLE = 2'd0,
        FSM_READ = 2'd1,
        FSM_ACC  = 2'd2,
        FSM_OUT  = 2'd3
    } fsm_t;

    typedef struct packed {
        logic [7:0] source;
        logic [7:0] target;
        logic [7:0] network;
        logic [7:0] direction;
        logic [6:0] size;
    } entry_t;

    function automatic status_t check_frame(input logic [7:0] len,
                                            input logic [47:0] hdr,
                                            input logic [7:0] cluster,
                                            input logic [7:0] network,
                                            input logic blocked,
                                            input logic full);
        logic [8:0] need;
        need = 9'(HdrBytes) + {1'b0, hdr[47:40]};
        if (len < 8'd4) return ST_SHORT;
        if (hdr[7:0] != cluster) return ST_OTHER;
        if (hdr[31:24] != network) return ST_NETWORK;
        if (len < 8'(HdrBytes)) return ST_SHORT;
        if (hdr[47:40] > 8'(MaxPayload)) return ST_BADSIZE;
        if ({1'b0, len} < need) return ST_SHORT;
        if (blocked || full) return ST_FULL;
        return ST_ACCEPTED;
    endfunction
endpackage
`default_nettype wire

### src/mesh_frame_filter_relay_queue.sv
// Top level: frame filter, frame queue in memory and chunked transmit sequencer
//
// channel | direction | contents
// s_      | in        | tuser mode, tdata rx_byte, tlast rx_last
// m_      | out       | tuser kind, tdata chunk/count/status/queue_count, tlast last
// cfg_    | in        | register write, no read-back
//
// A send runs, for each frame byte, a payload memory read and then byte assembly,
// and puts out the frame as chunks of up to eight bytes each.
// Reset is synchronous; the payload memory is not cleared.
// A stalled output holds the sequencer; input is taken only when idle.
`default_nettype none
module mesh_frame_filter_relay_queue (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // rx_byte[7:0]
    input  wire logic [1:0]  s_tuser,   // mode[1:0]
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [79:0]      m_tdata,   // tx_chunk[63:0], tx_count[67:64],
                                        // status[70:68], queue_count[77:71], zero
    output logic             m_tuser,   // kind
    output logic             m_tlast,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_wdata
);
    localparam int QW = mffrq_pkg::QW;
    localparam int CW = mffrq_pkg::CW;
    localparam int OW = mffrq_pkg::OW;

    logic [7:0] cluster_reg, network_reg, gateway_reg, node_reg;

    logic [7:0] mem [mffrq_pkg::MemDepth];
    logic [7:0] rd_q_reg;
    mffrq_pkg::entry_t ent_reg [mffrq_pkg::QueueDepth];

    logic [QW-1:0] head_reg, head_next, tail_reg, tail_next;
    logic [CW-1:0] count_reg, count_next;
    logic [6:0]    pos_reg, pos_next;
    logic [47:0]   hdr_reg, hdr_next, hdr_now;
    logic          blocked_reg, blocked_next;

    mffrq_pkg::fsm_t state_reg, state_next;
    logic [6:0]  idx_reg, idx_next;
    logic [3:0]  n_reg, n_next;
    logic [63:0] chunk_reg, chunk_next;

    logic        ov_reg, ov_next, okind_reg, okind_next, olast_reg, olast_next;
    logic [63:0] ochunk_reg, ochunk_next;
    logic [3:0]  ocnt_reg, ocnt_next;
    logic [2:0]  ost_reg, ost_next;
    logic [6:0]  oqc_reg, oqc_next;

    logic out_free, accept, mem_we;
    logic [mffrq_pkg::MW-1:0] mem_waddr, mem_raddr;
    logic [6:0] off_w, off_r, total;
    logic [7:0] len, dir, hop, hbyte, abyte;
    mffrq_pkg::status_t st;
    mffrq_pkg::entry_t head_ent;
    mffrq_pkg::mode_t mode;

    assign mode     = mffrq_pkg::mode_t'(s_tuser);
    assign out_free = !ov_reg || m_tready;
    assign s_tready = (state_reg == mffrq_pkg::FSM_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;
    assign head_ent = ent_reg[head_reg];
    assign total    = 7'(mffrq_pkg::HdrBytes) + head_ent.size;
    assign len      = {1'b0, pos_reg} + 8'd1;
    assign off_w    = pos_reg - 7'(mffrq_pkg::HdrBytes);
    assign off_r    = idx_reg - 7'(mffrq_pkg::HdrBytes);
    assign mem_waddr = {tail_reg, off_w[OW-1:0]};
    assign mem_raddr = {head_reg, off_r[OW-1:0]};
    assign mem_we   = accept && (mode == mffrq_pkg::MODE_RX)
                      && (pos_reg >= 7'(mffrq_pkg::HdrBytes))
                      && (off_w < 7'(mffrq_pkg::MaxPayload))
                      && (count_reg < CW'(mffrq_pkg::QueueDepth));

    always_comb begin
        hdr_now = hdr_reg;
        for (int i = 0; i < mffrq_pkg::HdrBytes; i++) begin
            if (pos_reg == 7'(i)) hdr_now[8*i +: 8] = s_tdata;
        end
    end

    assign st = mffrq_pkg::check_frame(len, hdr_now, cluster_reg, network_reg, blocked_reg,
                                       count_reg >= CW'(mffrq_pkg::QueueDepth));

    assign dir = head_ent.direction;
    assign hop = (dir == 8'd0) ? gateway_reg : ((dir == 8'd1) ? node_reg : 8'd0);
    always_comb begin
        case (idx_reg)
            7'd0:    hbyte = hop;
            7'd1:    hbyte = head_ent.source;
            7'd2:    hbyte = head_ent.target;
            7'd3:    hbyte = head_ent.network;
            7'd4:    hbyte = dir;
            7'd5:    hbyte = {1'b0, head_ent.size};
            default: hbyte = 8'd0;
        endcase
    end
    assign abyte = (idx_reg < 7'(mffrq_pkg::HdrBytes)) ? hbyte : rd_q_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            mffrq_pkg::FSM_IDLE: begin
                if (accept && mode == mffrq_pkg::MODE_SEND && count_reg != '0)
                    state_next = mffrq_pkg::FSM_READ;
            end
            mffrq_pkg::FSM_READ: state_next = mffrq_pkg::FSM_ACC;
            mffrq_pkg::FSM_ACC: begin
                if (n_reg == 4'd7 || idx_reg + 7'd1 == total)
                    state_next = mffrq_pkg::FSM_OUT;
                else
                    state_next = mffrq_pkg::FSM_READ;
            end
            mffrq_pkg::FSM_OUT: begin
                if (out_free)
                    state_next = (idx_reg == total) ? mffrq_pkg::FSM_IDLE
                                                    : mffrq_pkg::FSM_READ;
            end
            default: state_next = mffrq_pkg::FSM_IDLE;
        endcase
    end

    always_comb begin
        head_next = head_reg;   tail_next = tail_reg;   count_next = count_reg;
        pos_next = pos_reg;     hdr_next = hdr_reg;     blocked_next = blocked_reg;
        idx_next = idx_reg;     n_next = n_reg;         chunk_next = chunk_reg;
        ov_next = ov_reg && !m_tready;
        okind_next = okind_reg; olast_next = olast_reg; ochunk_next = ochunk_reg;
        ocnt_next = ocnt_reg;   ost_next = ost_reg;     oqc_next = oqc_reg;
        case (state_reg)
            mffrq_pkg::FSM_IDLE: begin
                if (accept) begin
                    okind_next = 1'b0; olast_next = 1'b1;
                    ochunk_next = '0;  ocnt_next = '0;
                    case (mode)
                        mffrq_pkg::MODE_RX: begin
                            hdr_next = hdr_now;
                            if (pos_reg >= 7'(mffrq_pkg::HdrBytes)
                                && off_w < 7'(mffrq_pkg::MaxPayload)
                                && count_reg >= CW'(mffrq_pkg::QueueDepth))
                                blocked_next = 1'b1;
                            if (pos_reg != 7'd127) pos_next = pos_reg + 7'd1;
                            if (s_tlast) begin
                                ov_next = 1'b1;
                                ost_next = st;
                                oqc_next = 7'(count_reg);
                                if (st == mffrq_pkg::ST_ACCEPTED) begin
                                    tail_next = (tail_reg == QW'(mffrq_pkg::QueueDepth - 1))
                                                ? '0 : tail_reg + QW'(1);
                                    count_next = count_reg + CW'(1);
                                    oqc_next = 7'(count_reg + CW'(1));
                                end
                                pos_next = '0; hdr_next = '0; blocked_next = 1'b0;
                            end
                        end
                        mffrq_pkg::MODE_SEND: begin
                            if (count_reg == '0) begin
                                ov_next = 1'b1; ost_next = mffrq_pkg::ST_EMPTY;
                                oqc_next = 7'(count_reg);
                            end
                            idx_next = '0; n_next = '0; chunk_next = '0;
                        end
                        mffrq_pkg::MODE_DONE: begin
                            ov_next = 1'b1;
                            if (count_reg == '0) begin
                                ost_next = mffrq_pkg::ST_EMPTY;
                                oqc_next = 7'(count_reg);
                            end else begin
                                head_next = (head_reg == QW'(mffrq_pkg::QueueDepth - 1))
                                            ? '0 : head_reg + QW'(1);
                                count_next = count_reg - CW'(1);
                                ost_next = mffrq_pkg::ST_POPPED;
                                oqc_next = 7'(count_reg - CW'(1));
                            end
                        end
                        default: ov_next = ov_reg && !m_tready;
                    endcase
                end
            end
            mffrq_pkg::FSM_ACC: begin
                chunk_next[8*n_reg[2:0] +: 8] = abyte;
                n_next = n_reg + 4'd1;
                idx_next = idx_reg + 7'd1;
            end
            mffrq_pkg::FSM_OUT: begin
                if (out_free) begin
                    ov_next = 1'b1; okind_next = 1'b1;
                    olast_next = (idx_reg == total);
                    ochunk_next = chunk_reg; ocnt_next = n_reg;
                    ost_next = mffrq_pkg::ST_ACCEPTED; oqc_next = 7'(count_reg);
                    chunk_next = '0; n_next = '0;
                end
            end
            default: ov_next = ov_reg && !m_tready;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) mem[mem_waddr] <= s_tdata;
        if (state_reg == mffrq_pkg::FSM_READ) rd_q_reg <= mem[mem_raddr];
        if (accept && mode == mffrq_pkg::MODE_RX && s_tlast
            && st == mffrq_pkg::ST_ACCEPTED) begin
            ent_reg[tail_reg].source    <= hdr_now[15:8];
            ent_reg[tail_reg].target    <= hdr_now[23:16];
            ent_reg[tail_reg].network   <= hdr_now[31:24];
            ent_reg[tail_reg].direction <= (hdr_now[23:16] == cluster_reg)
                                           ? 8'd0 : hdr_now[39:32];
            ent_reg[tail_reg].size      <= hdr_now[46:40];
        end
        idx_reg <= idx_next; n_reg <= n_next; chunk_reg <= chunk_next;
        okind_reg <= okind_next; olast_reg <= olast_next; ochunk_reg <= ochunk_next;
        ocnt_reg <= ocnt_next; ost_reg <= ost_next; oqc_reg <= oqc_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cluster_reg <= 8'd1; network_reg <= 8'd1;
            gateway_reg <= 8'd255; node_reg <= 8'd0;
            head_reg <= '0; tail_reg <= '0; count_reg <= '0;
            pos_reg <= '0; hdr_reg <= '0; blocked_reg <= 1'b0;
            state_reg <= mffrq_pkg::FSM_IDLE; ov_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (mffrq_pkg::reg_index_t'(cfg_index))
                    mffrq_pkg::REG_CLUSTER: cluster_reg <= cfg_wdata;
                    mffrq_pkg::REG_NETWORK: network_reg <= cfg_wdata;
                    mffrq_pkg::REG_GATEWAY: gateway_reg <= cfg_wdata;
                    mffrq_pkg::REG_NODE:    node_reg    <= cfg_wdata;
                    default:                node_reg    <= node_reg;
                endcase
            end
            head_reg <= head_next; tail_reg <= tail_next; count_reg <= count_next;
            pos_reg <= pos_next; hdr_reg <= hdr_next; blocked_reg <= blocked_next;
            state_reg <= state_next; ov_reg <= ov_next;
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tuser  = okind_reg;
    assign m_tlast  = olast_reg;
    assign m_tdata  = {2'b00, oqc_reg, ost_reg, ocnt_reg, ochunk_reg};
endmodule
`default_nettype wire

### src/mffrq_checker.sv
// Checker: port-level properties of the relay queue and its bind
`default_nettype none
module mffrq_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [79:0] m_tdata,
    input wire logic        m_tuser,
    input wire logic        m_tlast
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");
    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tlast && m_tdata[67:0] == 68'd0)
        else $error("status transfer not final or carries data");
    a_chunk: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[67:64] != 4'd0 && m_tdata[67:64] <= 4'd8
                                && m_tdata[70:68] == 3'd0)
        else $error("bad chunk transfer");
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[77:71] <= 7'(mffrq_pkg::QueueDepth))
        else $error("queue count out of range");
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid after reset");
endmodule

bind mesh_frame_filter_relay_queue mffrq_checker u_mffrq_checker (
    .aclk(aclk), .aresetn(aresetn), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tlast(m_tlast)
);
`default_nettype wire

### dv/mesh_frame_filter_relay_queue_tb.sv
// Testbench: random and directed frame, send and pop traffic checked against a relay queue model
`timescale 1ns / 100ps
module mesh_frame_filter_relay_queue_tb;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_CHUNK  = 1'b1;
    localparam int   LIMIT       = 200000;
    localparam int   SETTLE      = 200;

    typedef struct {
        logic        kind;
        logic [63:0] chunk;
        logic [3:0]  count;
        logic        last;
        logic [2:0]  status;
        logic [6:0]  qcount;
    } relay_result_t;

    class relay_scoreboard;
        logic [7:0] payload [mffrq_pkg::QueueDepth][mffrq_pkg::MaxPayload];
        logic [7:0] e_src [mffrq_pkg::QueueDepth];
        logic [7:0] e_tgt [mffrq_pkg::QueueDepth];
        logic [7:0] e_net [mffrq_pkg::QueueDepth];
        logic [7:0] e_dir [mffrq_pkg::QueueDepth];
        logic [6:0] e_size [mffrq_pkg::QueueDepth];
        int head, tail, count, pos;
        logic [47:0] hdr;
        bit blocked;
        logic [7:0] cluster, network, gw_hop, node_hop;
        relay_result_t pending [$];
        int errors;

        function new();
            head = 0; tail = 0; count = 0; pos = 0; hdr = '0; blocked = 0;
            cluster = 8'd1; network = 8'd1; gw_hop = 8'd255; node_hop = 8'd0;
            errors = 0;
        endfunction

        function void set_reg(mffrq_pkg::reg_index_t idx, logic [7:0] v);
            case (idx)
                mffrq_pkg::REG_CLUSTER: cluster = v;
                mffrq_pkg::REG_NETWORK: network = v;
                mffrq_pkg::REG_GATEWAY: gw_hop = v;
                default:                node_hop = v;
            endcase
        endfunction

        function void add(logic kind, logic [63:0] chunk, logic [3:0] n, logic last,
                          mffrq_pkg::status_t st);
            relay_result_t r;
            r.kind = kind; r.chunk = chunk; r.count = n; r.last = last;
            r.status = st; r.qcount = 7'(count);
            pending = {pending, r};
        endfunction

        function mffrq_pkg::status_t frame_status(int len);
            int size;
            size = hdr[47:40];
            if (len < 4) return mffrq_pkg::ST_SHORT;
            if (hdr[7:0] != cluster) return mffrq_pkg::ST_OTHER;
            if (hdr[31:24] != network) return mffrq_pkg::ST_NETWORK;
            if (len < 6) return mffrq_pkg::ST_SHORT;
            if (size > mffrq_pkg::MaxPayload) return mffrq_pkg::ST_BADSIZE;
            if (len < 6 + size) return mffrq_pkg::ST_SHORT;
            if (blocked || count >= mffrq_pkg::QueueDepth) return mffrq_pkg::ST_FULL;
            return mffrq_pkg::ST_ACCEPTED;
        endfunction

        function logic [7:0] frame_byte(int slot, int i);
            logic [7:0] d;
            d = e_dir[slot];
            case (i)
                0: return d == 0 ? gw_hop : (d == 1 ? node_hop : 8'd0);
                1: return e_src[slot];
                2: return e_tgt[slot];
                3: return e_net[slot];
                4: return d;
                5: return {1'b0, e_size[slot]};
                default: return payload[slot][i - 6];
            endcase
        endfunction

        function void note_input(logic [1:0] mode, logic [7:0] b, logic lastb);
            int len, total, i, n;
            mffrq_pkg::status_t st;
            logic [63:0] chunk;
            case (mode)
                mffrq_pkg::MODE_RX: begin
                    if (pos < 6) hdr[8*pos +: 8] = b;
                    else if (pos - 6 < mffrq_pkg::MaxPayload) begin
                        if (count < mffrq_pkg::QueueDepth) payload[tail][pos - 6] = b;
                        else blocked = 1;
                    end
                    len = pos + 1;
                    if (pos < 127) pos++;
                    if (lastb) begin
                        st = frame_status(len);
                        if (st == mffrq_pkg::ST_ACCEPTED) begin
                            e_src[tail] = hdr[15:8];
                            e_tgt[tail] = hdr[23:16];
                            e_net[tail] = hdr[31:24];
                            e_dir[tail] = (hdr[23:16] == cluster) ? 8'd0 : hdr[39:32];
                            e_size[tail] = hdr[46:40];
                            tail = (tail + 1) % mffrq_pkg::QueueDepth;
                            count++;
                        end
                        pos = 0; hdr = '0; blocked = 0;
                        add(KIND_STATUS, '0, '0, 1'b1, st);
                    end
                end
                mffrq_pkg::MODE_SEND: begin
                    if (count == 0) add(KIND_STATUS, '0, '0, 1'b1, mffrq_pkg::ST_EMPTY);
                    else begin
                        total = 6 + e_size[head];
                        i = 0;
                        while (i < total) begin
                            chunk = '0;
                            n = 0;
                            while (n < 8 && i < total) begin
                                chunk |= 64'(frame_byte(head, i)) << (8 * n);
                                n++;
                                i++;
                            end
                            add(KIND_CHUNK, chunk, 4'(n), i >= total, mffrq_pkg::ST_ACCEPTED);
                        end
                    end
                end
                mffrq_pkg::MODE_DONE: begin
                    if (count == 0) add(KIND_STATUS, '0, '0, 1'b1, mffrq_pkg::ST_EMPTY);
                    else begin
                        head = (head + 1) % mffrq_pkg::QueueDepth;
                        count--;
                        add(KIND_STATUS, '0, '0, 1'b1, mffrq_pkg::ST_POPPED);
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_result(logic kind, logic [79:0] data, logic last);
            relay_result_t e;
            if (pending.size() == 0) begin
                if (errors < 10) $display("unexpected transfer kind=%0d data=%h", kind, data);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (kind !== e.kind || data[63:0] !== e.chunk || data[67:64] !== e.count ||
                    data[70:68] !== e.status || data[77:71] !== e.qcount ||
                    data[79:78] !== 2'b00 || last !== e.last) begin
                if (errors < 10) begin
                    $display("mismatch exp kind=%0d chunk=%h cnt=%0d st=%0d qc=%0d last=%0d",
                             e.kind, e.chunk, e.count, e.status, e.qcount, e.last);
                    $display("         act kind=%0d chunk=%h cnt=%0d st=%0d qc=%0d last=%0d",
                             kind, data[63:0], data[67:64], data[70:68], data[77:71], last);
                end
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic [1:0]  s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [7:0]  cfg_wdata;

    relay_scoreboard sb;
    int send_idle_pct;
    int recv_stall_pct;
    int cycles;
    int items_sent;

    mesh_frame_filter_relay_queue u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("[mesh_frame_filter_relay_queue] ERROR");
            $finish;
        end
    end

    always @(negedge aclk) m_tready = ($urandom_range(0, 99) >= recv_stall_pct);

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata, m_tlast);
    end

    task automatic push_item(logic [1:0] mode, logic [7:0] b, logic lastb);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
            s_tdata = 8'($urandom);
            repeat ($urandom_range(0, 3)) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tuser = mode;
        s_tdata = b;
        s_tlast = lastb;
        do @(posedge aclk); while (!s_tready);
        sb.note_input(mode, b, lastb);
        items_sent++;
    endtask

    task automatic send_frame(logic [7:0] hop, logic [7:0] tgt, logic [7:0] net,
                              logic [7:0] dir, logic [7:0] size, int len);
        logic [7:0] b;
        for (int i = 0; i < len; i++) begin
            case (i)
                0: b = hop;
                2: b = tgt;
                3: b = net;
                4: b = dir;
                5: b = size;
                default: b = 8'($urandom);
            endcase
            push_item(mffrq_pkg::MODE_RX, b, i == len - 1);
        end
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(mffrq_pkg::reg_index_t idx, logic [7:0] v);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = v;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        sb.set_reg(idx, v);
    endtask

    task automatic random_traffic(int n_items);
        int r, size, target;
        logic [7:0] tgt;
        target = items_sent + n_items;
        while (items_sent < target) begin
            r = $urandom_range(0, 99);
            size = ($urandom_range(0, 19) == 0) ? mffrq_pkg::MaxPayload
                                                : $urandom_range(0, 12);
            tgt = $urandom_range(0, 1) ? sb.cluster : 8'($urandom);
            if (r < 50)
                send_frame(sb.cluster, tgt, sb.network,
                           $urandom_range(0, 5) == 0 ? 8'($urandom) : 8'($urandom_range(0, 2)),
                           8'(size), 6 + size + ($urandom_range(0, 7) == 0 ? 3 : 0));
            else if (r < 62) begin
                case ($urandom_range(0, 3))
                    0: send_frame(8'($urandom), tgt, sb.network, 8'd1, 8'd2, 8);
                    1: send_frame(sb.cluster, tgt, 8'($urandom), 8'd0, 8'd2, 8);
                    2: send_frame(sb.cluster, tgt, sb.network, 8'd0,
                                  8'($urandom_range(65, 255)), 7);
                    default: send_frame(sb.cluster, tgt, sb.network, 8'd1,
                                        8'(size), $urandom_range(1, 5 + size));
                endcase
            end
            else if (r < 78) push_item(mffrq_pkg::MODE_SEND, 8'($urandom), 1'($urandom));
            else if (r < 93) push_item(mffrq_pkg::MODE_DONE, 8'($urandom), 1'($urandom));
            else if (r < 97) push_item(mffrq_pkg::MODE_NONE, 8'($urandom), 1'($urandom));
            else push_item(mffrq_pkg::MODE_RX, 8'($urandom), 1'b0);
        end
    endtask

    initial begin
        sb = new();
        cycles = 0;
        items_sent = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = mffrq_pkg::MODE_RX;
        s_tlast = 1'b0;
        m_tready = 1'b1;
        cfg_wr_en = 1'b0;
        cfg_index = mffrq_pkg::REG_CLUSTER;
        cfg_wdata = '0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        push_item(mffrq_pkg::MODE_SEND, 8'h00, 1'b0);
        push_item(mffrq_pkg::MODE_DONE, 8'hFF, 1'b1);
        push_item(mffrq_pkg::MODE_NONE, 8'hA5, 1'b1);
        send_frame(8'd1, 8'd7, 8'd1, 8'd1, 8'd64, 73);
        send_frame(8'd1, 8'd1, 8'd1, 8'd1, 8'd3, 9);
        send_frame(8'd1, 8'd9, 8'd1, 8'd0, 8'd0, 3);
        send_frame(8'd1, 8'd9, 8'd1, 8'd0, 8'd0, 5);
        send_frame(8'd2, 8'd9, 8'd1, 8'd0, 8'd0, 6);
        send_frame(8'd1, 8'd9, 8'd2, 8'd0, 8'd0, 6);
        send_frame(8'd1, 8'd9, 8'd1, 8'd0, 8'd65, 6);
        while (sb.count < mffrq_pkg::QueueDepth)
            send_frame(8'd1, 8'd9, 8'd1, 8'(sb.count % 3), 8'd0, 6);
        send_frame(8'd1, 8'd9, 8'd1, 8'd1, 8'd0, 6);
        send_frame(8'd1, 8'd9, 8'd1, 8'd1, 8'd2, 7);
        push_item(mffrq_pkg::MODE_DONE, 8'h00, 1'b0);
        push_item(mffrq_pkg::MODE_RX, 8'h5A, 1'b1);
        while (sb.count > 0) begin
            push_item(mffrq_pkg::MODE_SEND, 8'h00, 1'b0);
            push_item(mffrq_pkg::MODE_DONE, 8'h00, 1'b0);
        end
        push_item(mffrq_pkg::MODE_DONE, 8'h00, 1'b0);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
                default: begin send_idle_pct = 26; recv_stall_pct = 26; end
            endcase
            case (ph)
                1: begin
                    write_reg(mffrq_pkg::REG_CLUSTER, 8'd0);
                    write_reg(mffrq_pkg::REG_NETWORK, 8'd255);
                    write_reg(mffrq_pkg::REG_GATEWAY, 8'd0);
                    write_reg(mffrq_pkg::REG_NODE, 8'd255);
                end
                2: begin
                    write_reg(mffrq_pkg::REG_CLUSTER, 8'd255);
                    write_reg(mffrq_pkg::REG_NETWORK, 8'd0);
                    write_reg(mffrq_pkg::REG_GATEWAY, 8'hA5);
                    write_reg(mffrq_pkg::REG_NODE, 8'h5A);
                end
                3: begin
                    write_reg(mffrq_pkg::REG_CLUSTER, 8'($urandom));
                    write_reg(mffrq_pkg::REG_NETWORK, 8'($urandom));
                    write_reg(mffrq_pkg::REG_GATEWAY, 8'($urandom));
                    write_reg(mffrq_pkg::REG_NODE, 8'($urandom));
                end
                default: ;
            endcase
            random_traffic(12);
            drain();
        end

        if (sb.errors == 0) $display("[mesh_frame_filter_relay_queue] OK");
        else $display("[mesh_frame_filter_relay_queue] ERROR");
        $finish;
    end
endmodule
